/* rtl/lcsa_pkg.sv */
// ----------------------------------------------------------------------------
// lcsa_pkg: shared types and constants of the linked cell store allocator
// Port widths, operation and status codes, and the formats of the words queued
// between the front and back sections and of the result word.
// ----------------------------------------------------------------------------
package lcsa_pkg;

  localparam int CELLS_DEF     = 64;
  localparam int TAG_BITS_DEF  = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 6;
  localparam int TAG_W   = 16;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Classified input word as queued between front and back.
  typedef struct packed {
    op_t                        op;
    logic [ADDR_W-1:0]          chain_addr;
    logic                       addr_in;
    logic [TAG_W-1:0]           tag;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         run_count;
    logic                       run_first;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [ADDR_W-1:0]          head_addr;
    logic signed [VALUE_W-1:0]  read_value;
    logic [1:0]                 status;
    logic                       run_done;
    logic [COUNT_W-1:0]         free_count;
  } res_t;

endpackage

/* rtl/lcsa_ram.sv */
// ----------------------------------------------------------------------------
// lcsa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lcsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lcsa_front.sv */
// ----------------------------------------------------------------------------
// lcsa_front: input acceptance and classification
// Takes input words, flags out-of-pool addresses and holds them in a
// two-entry queue for the back section.
// ----------------------------------------------------------------------------
module lcsa_front #(
  parameter int CELLS = lcsa_pkg::CELLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              hold,
  input  logic                              push,
  output logic                              full,
  input  logic [lcsa_pkg::OP_W-1:0]         in_op,
  input  logic [lcsa_pkg::ADDR_W-1:0]       in_chain_addr,
  input  logic [lcsa_pkg::TAG_W-1:0]        in_tag,
  input  logic signed [lcsa_pkg::VALUE_W-1:0] in_value,
  input  logic [lcsa_pkg::COUNT_W-1:0]      in_run_count,
  input  logic                              in_run_first,
  output logic                              item_valid,
  output lcsa_pkg::item_t                   item,
  input  logic                              item_take
);

  lcsa_pkg::item_t q_r [2];
  logic            wptr_r, rptr_r;
  logic [1:0]      cnt_r;
  logic            acc;
  lcsa_pkg::item_t cls;

  assign full       = (cnt_r == 2'd2) || hold;
  assign acc        = push && !full;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rptr_r];

  always_comb begin
    cls.op         = lcsa_pkg::op_t'(in_op);
    cls.chain_addr = in_chain_addr;
    cls.addr_in    = (32'(in_chain_addr) < CELLS);
    cls.tag        = in_tag;
    cls.value      = in_value;
    cls.run_count  = in_run_count;
    cls.run_first  = in_run_first;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wptr_r] <= cls;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (acc) begin
        wptr_r <= ~wptr_r;
      end
      if (item_take && item_valid) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(acc) - 2'(item_take && item_valid);
    end
  end

endmodule

/* rtl/lcsa_back.sv */
// ----------------------------------------------------------------------------
// lcsa_back: cell store sequencer
// Carries out allocate, free, write and read words against the cell RAMs
// and holds the result register.
// ----------------------------------------------------------------------------
module lcsa_back #(
  parameter int CELLS     = lcsa_pkg::CELLS_DEF,
  parameter int TAG_BITS  = lcsa_pkg::TAG_BITS_DEF,
  parameter int DATA_BITS = lcsa_pkg::DATA_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  output logic            clearing,
  input  logic            item_valid,
  input  lcsa_pkg::item_t item,
  output logic            item_take,
  output logic            out_valid,
  output lcsa_pkg::res_t  out_res,
  input  logic            out_pop
);

  localparam int AW  = $clog2(CELLS);
  localparam int LW  = AW + 1;
  localparam int CW  = $clog2(CELLS + 1);
  localparam int RLW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_A_RD, S_A_WR, S_F_RD, S_F_CHK,
    S_C_RD, S_C_WR, S_W_RD, S_W_CHK, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  lcsa_pkg::item_t cur_r, cur_nxt;
  logic [LW-1:0]   free_head_r, free_head_nxt;
  logic [CW-1:0]   free_cells_r, free_cells_nxt;
  logic [AW-1:0]   run_head_r, run_head_nxt;
  logic [RLW-1:0]  run_left_r, run_left_nxt;
  logic            run_refused_r, run_refused_nxt;
  logic [LW-1:0]   x_r, x_nxt;
  logic [LW-1:0]   tail_r, tail_nxt;
  logic [CW:0]     n_r, n_nxt;
  logic [CW-1:0]   steps_r, steps_nxt;
  lcsa_pkg::res_t  pend_r, pend_nxt;
  lcsa_pkg::res_t  out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic                 link_we, tag_we, data_we;
  logic [AW-1:0]        link_waddr, rd_addr;
  logic [LW:0]          link_wdata, link_rd;
  logic [TAG_BITS-1:0]  tag_rd;
  logic [DATA_BITS-1:0] data_wdata, data_rd;
  logic [AW-1:0]        data_waddr;
  logic                 rd_free;
  logic [LW-1:0]        rd_link;
  logic                 rd_end;
  logic [TAG_BITS-1:0]  cur_tag;
  logic [CW-1:0]        alloc_cnt;
  logic [CW:0]          free_sum;
  logic [RLW-1:0]       rl_dec;

  assign rd_free   = link_rd[LW];
  assign rd_link   = link_rd[LW-1:0];
  assign rd_end    = (rd_link >= LW'(CELLS));
  assign cur_tag   = TAG_BITS'(cur_r.tag);
  assign alloc_cnt = CW'(CELLS) - free_cells_r;
  assign free_sum  = (CW+1)'(free_cells_r) + n_r;
  assign rl_dec    = run_left_r - RLW'(1);

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  lcsa_ram #(.WIDTH(LW + 1), .DEPTH(CELLS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(rd_addr), .rdata(link_rd)
  );

  lcsa_ram #(.WIDTH(TAG_BITS), .DEPTH(CELLS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(AW'(free_head_r)), .wdata(cur_tag),
    .raddr(rd_addr), .rdata(tag_rd)
  );

  lcsa_ram #(.WIDTH(DATA_BITS), .DEPTH(CELLS)) u_data_ram (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(rd_addr), .rdata(data_rd)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    cur_nxt         = cur_r;
    free_head_nxt   = free_head_r;
    free_cells_nxt  = free_cells_r;
    run_head_nxt    = run_head_r;
    run_left_nxt    = run_left_r;
    run_refused_nxt = run_refused_r;
    x_nxt           = x_r;
    tail_nxt        = tail_r;
    n_nxt           = n_r;
    steps_nxt       = steps_r;
    pend_nxt        = pend_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    item_take       = 1'b0;
    link_we         = 1'b0;
    link_waddr      = AW'(x_r);
    link_wdata      = {1'b1, rd_link};
    tag_we          = 1'b0;
    data_we         = 1'b0;
    data_waddr      = AW'(x_r);
    data_wdata      = DATA_BITS'(cur_r.value);
    rd_addr         = AW'(x_r);

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_r;
        link_wdata = {1'b1, LW'(clr_r) + LW'(1)};
        data_we    = 1'b1;
        data_waddr = clr_r;
        data_wdata = '0;
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          cur_nxt   = item;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        pend_nxt  = '{default: '0};
        state_nxt = S_OUT;
        case (cur_r.op)
          lcsa_pkg::OP_ALLOC: begin
            pend_nxt.status = lcsa_pkg::ST_REFUSED;
            if (cur_r.run_first) begin
              if (run_left_r != '0 && !run_refused_r) begin
                pend_nxt.run_done = 1'b0;
              end else if (cur_r.run_count == '0 ||
                           RLW'(cur_r.run_count) > RLW'(free_cells_r)) begin
                run_left_nxt      = (cur_r.run_count == '0) ? '0 :
                                    RLW'(cur_r.run_count) - RLW'(1);
                run_refused_nxt   = (run_left_nxt != '0);
                pend_nxt.run_done = (run_left_nxt == '0);
              end else begin
                run_head_nxt    = AW'(free_head_r);
                run_left_nxt    = RLW'(cur_r.run_count);
                run_refused_nxt = 1'b0;
                state_nxt       = S_A_RD;
              end
            end else if (run_left_r == '0) begin
              pend_nxt.run_done = 1'b0;
            end else if (run_refused_r) begin
              run_left_nxt      = rl_dec;
              run_refused_nxt   = (rl_dec != '0);
              pend_nxt.run_done = (rl_dec == '0);
            end else begin
              state_nxt = S_A_RD;
            end
            // An exhausted free list ends the run at once.
            if (state_nxt == S_A_RD &&
                (free_head_r >= LW'(CELLS) || free_cells_r == '0)) begin
              run_left_nxt      = '0;
              pend_nxt.run_done = 1'b1;
              state_nxt         = S_OUT;
            end
          end
          lcsa_pkg::OP_FREE: begin
            if ((run_left_r != '0 && !run_refused_r) || !cur_r.addr_in) begin
              pend_nxt.status = lcsa_pkg::ST_REFUSED;
            end else begin
              x_nxt     = LW'(cur_r.chain_addr);
              n_nxt     = '0;
              state_nxt = S_F_RD;
            end
          end
          default: begin
            if (!cur_r.addr_in) begin
              pend_nxt.status = (cur_r.op == lcsa_pkg::OP_WRITE) ?
                                lcsa_pkg::ST_OK : lcsa_pkg::ST_NOT_FOUND;
            end else begin
              x_nxt     = LW'(cur_r.chain_addr);
              steps_nxt = '0;
              state_nxt = S_W_RD;
            end
          end
        endcase
      end
      S_A_RD: begin
        rd_addr   = AW'(free_head_r);
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        link_we           = 1'b1;
        link_waddr        = AW'(free_head_r);
        link_wdata        = {1'b0, (rl_dec == '0) ? LW'(CELLS) : rd_link};
        tag_we            = 1'b1;
        free_head_nxt     = rd_link;
        free_cells_nxt    = free_cells_r - CW'(1);
        run_left_nxt      = rl_dec;
        pend_nxt          = '{default: '0};
        pend_nxt.head_addr = lcsa_pkg::ADDR_W'(run_head_r);
        pend_nxt.status   = lcsa_pkg::ST_OK;
        pend_nxt.run_done = (rl_dec == '0);
        state_nxt         = S_OUT;
      end
      S_F_RD: begin
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        // A cell already free, or more cells than are allocated, means the
        // chain overlaps the free list or loops on itself.
        if (rd_free || (n_r + (CW+1)'(1)) > (CW+1)'(alloc_cnt)) begin
          pend_nxt.status = lcsa_pkg::ST_REFUSED;
          state_nxt       = S_OUT;
        end else begin
          n_nxt    = n_r + (CW+1)'(1);
          tail_nxt = x_r;
          if (rd_end) begin
            x_nxt     = LW'(cur_r.chain_addr);
            state_nxt = S_C_RD;
          end else begin
            x_nxt     = rd_link;
            state_nxt = S_F_RD;
          end
        end
      end
      S_C_RD: begin
        state_nxt = S_C_WR;
      end
      S_C_WR: begin
        link_we = 1'b1;
        if (x_r == tail_r) begin
          link_wdata     = {1'b1, free_head_r};
          free_head_nxt  = LW'(cur_r.chain_addr);
          free_cells_nxt = (free_sum > (CW+1)'(CELLS)) ? CW'(CELLS) : CW'(free_sum);
          pend_nxt.status = lcsa_pkg::ST_OK;
          state_nxt      = S_OUT;
        end else begin
          x_nxt     = rd_link;
          state_nxt = S_C_RD;
        end
      end
      S_W_RD: begin
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (tag_rd == cur_tag && cur_r.op == lcsa_pkg::OP_READ) begin
          pend_nxt.read_value = 32'(signed'(data_rd));
          pend_nxt.status     = lcsa_pkg::ST_OK;
          state_nxt           = S_OUT;
        end else begin
          data_we   = (tag_rd == cur_tag);
          steps_nxt = steps_r + CW'(1);
          if (steps_nxt == CW'(CELLS) || rd_end) begin
            pend_nxt.status = (cur_r.op == lcsa_pkg::OP_WRITE) ?
                              lcsa_pkg::ST_OK : lcsa_pkg::ST_NOT_FOUND;
            state_nxt       = S_OUT;
          end else begin
            x_nxt     = rd_link;
            state_nxt = S_W_RD;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_nxt            = pend_r;
          out_nxt.free_count = lcsa_pkg::COUNT_W'(free_cells_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    x_r     <= x_nxt;
    tail_r  <= tail_nxt;
    n_r     <= n_nxt;
    steps_r <= steps_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      free_head_r   <= '0;
      free_cells_r  <= CW'(CELLS);
      run_head_r    <= '0;
      run_left_r    <= '0;
      run_refused_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      free_head_r   <= free_head_nxt;
      free_cells_r  <= free_cells_nxt;
      run_head_r    <= run_head_nxt;
      run_left_r    <= run_left_nxt;
      run_refused_r <= run_refused_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

endmodule

/* rtl/linked_cell_store_allocator.sv */
// ----------------------------------------------------------------------------
// linked_cell_store_allocator: pool of linked cells with a free list
// Allocates tagged chains, frees them, and writes or reads data by tag.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Word
//   --------  ------------------  ------------------------------------------
//   input     push / full         op, chain_addr, tag, value, run_count,
//                                 run_first
//   result    empty / pop         head_addr, read_value, status, run_done,
//                                 free_count
//
// Every word gives exactly one result word. An accepted allocate word goes
// from the queue through decode, RAM read and RAM write to the result
// register; a refused one goes from decode straight to it. Write and read
// walk the chain, a read and a check state per cell, at most CELLS cells. A
// free walks its chain twice (check, then relink); the single read port of
// the cell RAMs gives each cell a read state. A clearing pass after reset
// initializes links and data of every cell; full stays high during it. The
// sequencer waits while a result word is not popped; a two-entry queue sits
// between front and sequencer, so input words are taken until it is full.
module linked_cell_store_allocator #(
  parameter int CELLS     = lcsa_pkg::CELLS_DEF,
  parameter int TAG_BITS  = lcsa_pkg::TAG_BITS_DEF,
  parameter int DATA_BITS = lcsa_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic [lcsa_pkg::OP_W-1:0]            in_op,
  input  logic [lcsa_pkg::ADDR_W-1:0]          in_chain_addr,
  input  logic [lcsa_pkg::TAG_W-1:0]           in_tag,
  input  logic signed [lcsa_pkg::VALUE_W-1:0]  in_value,
  input  logic [lcsa_pkg::COUNT_W-1:0]         in_run_count,
  input  logic                                 in_run_first,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [lcsa_pkg::ADDR_W-1:0]          out_head_addr,
  output logic signed [lcsa_pkg::VALUE_W-1:0]  out_read_value,
  output logic [1:0]                           out_status,
  output logic                                 out_run_done,
  output logic [lcsa_pkg::COUNT_W-1:0]         out_free_count
);

  logic            clearing;
  logic            item_valid, item_take;
  lcsa_pkg::item_t item;
  logic            out_valid;
  lcsa_pkg::res_t  out_res;

  // Front: accepts and classifies input words into the queue.
  lcsa_front #(.CELLS(CELLS)) u_front (
    .clk(clk), .rst_n(rst_n), .hold(clearing), .push(push), .full(full),
    .in_op(in_op), .in_chain_addr(in_chain_addr), .in_tag(in_tag),
    .in_value(in_value), .in_run_count(in_run_count),
    .in_run_first(in_run_first),
    .item_valid(item_valid), .item(item), .item_take(item_take)
  );

  // Back: walks and updates the cell store, owns the result register.
  lcsa_back #(.CELLS(CELLS), .TAG_BITS(TAG_BITS), .DATA_BITS(DATA_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .clearing(clearing),
    .item_valid(item_valid), .item(item), .item_take(item_take),
    .out_valid(out_valid), .out_res(out_res), .out_pop(pop)
  );

  assign empty          = !out_valid;
  assign out_head_addr  = out_res.head_addr;
  assign out_read_value = out_res.read_value;
  assign out_status     = out_res.status;
  assign out_run_done   = out_res.run_done;
  assign out_free_count = out_res.free_count;

  // The input side is closed while the clearing pass runs.
  a_clear_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> full)
    else $error("input open during clearing pass");

  // No result is presented before the store is initialized.
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> empty)
    else $error("result during clearing pass");

  // A presented result carries a defined status and a sane free count.
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status != 2'd3) && (32'(out_free_count) <= CELLS))
    else $error("result word out of range");

  // A word can only be taken by the sequencer if one is queued.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> item_valid)
    else $error("queue read while empty");

endmodule

/* verif/linked_cell_store_allocator_test.sv */
// ----------------------------------------------------------------------------
// linked_cell_store_allocator_test: self-checking bench for the cell allocator
// Drives directed and random allocate, free, write and read words through the
// push/full side, predicts every result word in a behavioral copy of the pool,
// and compares each popped result word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module linked_cell_store_allocator_test;

  localparam int NCELL   = 64;
  localparam int NULL_LK = NCELL;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 push;
  logic                                 full;
  logic [lcsa_pkg::OP_W-1:0]            in_op;
  logic [lcsa_pkg::ADDR_W-1:0]          in_chain_addr;
  logic [lcsa_pkg::TAG_W-1:0]           in_tag;
  logic signed [lcsa_pkg::VALUE_W-1:0]  in_value;
  logic [lcsa_pkg::COUNT_W-1:0]         in_run_count;
  logic                                 in_run_first;
  logic                                 empty;
  logic                                 pop;
  logic [lcsa_pkg::ADDR_W-1:0]          out_head_addr;
  logic signed [lcsa_pkg::VALUE_W-1:0]  out_read_value;
  logic [1:0]                           out_status;
  logic                                 out_run_done;
  logic [lcsa_pkg::COUNT_W-1:0]         out_free_count;

  linked_cell_store_allocator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_chain_addr  (in_chain_addr),
    .in_tag         (in_tag),
    .in_value       (in_value),
    .in_run_count   (in_run_count),
    .in_run_first   (in_run_first),
    .empty          (empty),
    .pop            (pop),
    .out_head_addr  (out_head_addr),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_run_done   (out_run_done),
    .out_free_count (out_free_count)
  );

  // Behavioral copy of the pool. Links use one extra bit so that NCELL can
  // stand for the end of a chain.
  logic [6:0]                    pool_link [NCELL];
  logic [lcsa_pkg::TAG_W-1:0]    pool_tag  [NCELL];
  logic [lcsa_pkg::VALUE_W-1:0]  pool_data [NCELL];
  bit                            tag_known [NCELL];
  int                            free_head;
  int                            free_cells;
  int                            run_head;
  int                            run_left;
  bit                            run_refused;

  lcsa_pkg::res_t  pending_results[$];
  int    chain_heads[$];
  int    words_sent;
  int    words_checked;
  int    mismatches;
  int    ok_runs;
  int    refusals;
  int    read_hits;
  int    send_burst;

  // Clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time, far above the slowest legal run.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic lcsa_pkg::res_t make_result(int head,
                                                 logic [lcsa_pkg::VALUE_W-1:0] rv,
                                                 logic [1:0] st, bit done);
    lcsa_pkg::res_t r;
    r.head_addr  = head[lcsa_pkg::ADDR_W-1:0];
    r.read_value = rv;
    r.status     = st;
    r.run_done   = done;
    r.free_count = free_cells[lcsa_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic reset_pool();
    for (int i = 0; i < NCELL; i++) begin
      pool_link[i] = 7'(i + 1);
      pool_tag[i]  = '0;
      pool_data[i] = '0;
      tag_known[i] = 1'b0;
    end
    free_head   = 0;
    free_cells  = NCELL;
    run_head    = 0;
    run_left    = 0;
    run_refused = 1'b0;
  endtask

  // One allocate word. A run's first word checks the space for the whole run.
  function automatic lcsa_pkg::res_t alloc_word(logic [lcsa_pkg::TAG_W-1:0] tag, int cnt,
                                                bit first);
    int d;
    if (first) begin
      if (run_left > 0 && !run_refused)
        return make_result(0, 0, lcsa_pkg::ST_REFUSED, 0);
      run_refused = 1'b0;
      run_left    = 0;
      if (cnt == 0 || cnt > free_cells) begin
        run_left    = (cnt == 0) ? 0 : cnt - 1;
        run_refused = (run_left > 0);
        return make_result(0, 0, lcsa_pkg::ST_REFUSED, run_left == 0);
      end
      run_head = free_head;
      run_left = cnt;
    end else begin
      if (run_left == 0) return make_result(0, 0, lcsa_pkg::ST_REFUSED, 0);
      if (run_refused) begin
        run_left--;
        if (run_left == 0) run_refused = 1'b0;
        return make_result(0, 0, lcsa_pkg::ST_REFUSED, run_left == 0);
      end
    end
    d = free_head;
    if (d >= NCELL || free_cells == 0) begin
      run_left = 0;
      return make_result(0, 0, lcsa_pkg::ST_REFUSED, 1);
    end
    pool_tag[d]  = tag;
    tag_known[d] = 1'b1;
    free_cells--;
    run_left--;
    free_head = pool_link[d];
    if (run_left == 0) pool_link[d] = 7'(NULL_LK);
    return make_result(run_head, 0, lcsa_pkg::ST_OK, run_left == 0);
  endfunction

  // Free pushes a whole chain onto the free list unless it overlaps the free
  // list or loops back on itself.
  function automatic lcsa_pkg::res_t free_chain(int addr);
    int  x, n, tail;
    byte seen [NCELL];
    if (run_left > 0 && !run_refused) return make_result(0, 0, lcsa_pkg::ST_REFUSED, 0);
    foreach (seen[i]) seen[i] = 0;
    x = free_head;
    for (int s = 0; s < NCELL && x < NCELL; s++) begin
      seen[x] = 1;
      x = pool_link[x];
    end
    n    = 0;
    tail = 0;
    x    = addr;
    while (1) begin
      if (seen[x] != 0) return make_result(0, 0, lcsa_pkg::ST_REFUSED, 0);
      seen[x] = 2;
      n++;
      tail = x;
      x = pool_link[x];
      if (x >= NCELL) break;
    end
    pool_link[tail] = 7'(free_head);
    free_head  = addr;
    free_cells = (free_cells + n > NCELL) ? NCELL : free_cells + n;
    return make_result(0, 0, lcsa_pkg::ST_OK, 0);
  endfunction

  function automatic lcsa_pkg::res_t pool_step(lcsa_pkg::op_t op, int addr,
                                               logic [lcsa_pkg::TAG_W-1:0] tag,
                                               logic [lcsa_pkg::VALUE_W-1:0] val,
                                               int cnt, bit first);
    int x;
    if (op == lcsa_pkg::OP_ALLOC) return alloc_word(tag, cnt, first);
    if (op == lcsa_pkg::OP_FREE) return free_chain(addr);
    x = addr;
    for (int s = 0; s < NCELL && x < NCELL; s++) begin
      if (pool_tag[x] == tag) begin
        if (op == lcsa_pkg::OP_WRITE) pool_data[x] = val;
        else return make_result(0, pool_data[x], lcsa_pkg::ST_OK, 0);
      end
      x = pool_link[x];
    end
    return make_result(0, 0, (op == lcsa_pkg::OP_WRITE) ? lcsa_pkg::ST_OK :
                       lcsa_pkg::ST_NOT_FOUND, 0);
  endfunction

  // A write or read may only walk over cells whose tag has been written.
  function automatic bit walk_is_tagged(int addr);
    int x;
    x = addr;
    for (int s = 0; s < NCELL && x < NCELL; s++) begin
      if (!tag_known[x]) return 1'b0;
      x = pool_link[x];
    end
    return 1'b1;
  endfunction

  // Picks a tag found somewhere along a chain.
  function automatic logic [lcsa_pkg::TAG_W-1:0] tag_on_chain(int addr);
    int x, k;
    x = addr;
    k = $urandom_range(0, 7);
    for (int s = 0; s < k; s++) begin
      if (pool_link[x] >= NCELL) break;
      x = pool_link[x];
    end
    return pool_tag[x];
  endfunction

  // Sends one word. The sender works in bursts; between bursts push is low
  // for a random gap. The word is predicted at the edge that accepts it.
  task automatic send_word(lcsa_pkg::op_t op, int addr, logic [lcsa_pkg::TAG_W-1:0] tag,
                           logic [lcsa_pkg::VALUE_W-1:0] val, int cnt, bit first);
    lcsa_pkg::res_t r;
    if (send_burst == 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      send_burst = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    send_burst--;
    push          = 1'b1;
    in_op         = op;
    in_chain_addr = addr[lcsa_pkg::ADDR_W-1:0];
    in_tag        = tag;
    in_value      = val;
    in_run_count  = cnt[lcsa_pkg::COUNT_W-1:0];
    in_run_first  = first;
    do @(posedge clk); while (full);
    r = pool_step(op, addr, tag, val, cnt, first);
    pending_results.push_back(r);
    words_sent++;
    if (r.status == lcsa_pkg::ST_REFUSED) refusals++;
    if (op == lcsa_pkg::OP_ALLOC && r.status == lcsa_pkg::ST_OK && r.run_done) begin
      ok_runs++;
      chain_heads.push_back(r.head_addr);
      if (chain_heads.size() > 32) void'(chain_heads.pop_front());
    end
    if (op == lcsa_pkg::OP_READ && r.status == lcsa_pkg::ST_OK) read_hits++;
  endtask

  // Lowers push and waits until every predicted word has been popped.
  task automatic drain_results();
    @(negedge clk);
    push = 1'b0;
    send_burst = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A whole run with random tags; cnt is the declared length.
  task automatic alloc_run(int cnt, int words);
    for (int i = 0; i < words; i++)
      send_word(lcsa_pkg::OP_ALLOC, $urandom_range(0, 63), 16'($urandom), $urandom, cnt,
                i == 0);
  endtask

  task automatic test_alloc_and_access();
    int h;
    // Count zero is refused and ends at once; a huge count is refused and the
    // refused run is then dropped by a new first word.
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h0000, 0, 0, 1);
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h0000, 0, 127, 1);
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h0000, 0, 127, 0);
    send_word(lcsa_pkg::OP_ALLOC, 63, 16'h0000, 32'hFFFF_FFFF, 3, 1);
    h = run_head;
    send_word(lcsa_pkg::OP_ALLOC, 63, 16'hFFFF, 0, 3, 0);
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h1234, 0, 3, 0);
    // A word with no run open.
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h5555, 0, 0, 0);
    send_word(lcsa_pkg::OP_WRITE, h, 16'hFFFF, 32'h8000_0000, 0, 0);
    send_word(lcsa_pkg::OP_WRITE, h, 16'h0000, 32'h7FFF_FFFF, 0, 0);
    send_word(lcsa_pkg::OP_READ, h, 16'hFFFF, 0, 0, 0);
    send_word(lcsa_pkg::OP_READ, h, 16'h0000, 0, 0, 0);
    send_word(lcsa_pkg::OP_READ, h, 16'hABCD, 0, 0, 0);
    // Write with no matching tag still reports ok.
    send_word(lcsa_pkg::OP_WRITE, h, 16'hABCD, 32'h1, 0, 0);
  endtask

  task automatic test_run_conflicts();
    int h;
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h00AA, 0, 2, 1);
    h = run_head;
    // A new first word and a free inside an accepted run are both refused.
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h00BB, 0, 5, 1);
    send_word(lcsa_pkg::OP_FREE, h, 0, 0, 0, 0);
    send_word(lcsa_pkg::OP_ALLOC, 0, 16'h00CC, 0, 2, 0);
    send_word(lcsa_pkg::OP_FREE, h, 0, 0, 0, 0);
    // Freeing the same chain again overlaps the free list.
    send_word(lcsa_pkg::OP_FREE, h, 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_random_traffic(int n_words);
    int sel, addr, k, len;
    bit found;
    while (words_sent < n_words) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // Mostly short runs, now and then the whole free list or too much.
        k = $urandom_range(0, 9);
        if (k == 0) alloc_run(free_cells, free_cells);
        else if (k == 1) alloc_run(free_cells + $urandom_range(1, 3), $urandom_range(1, 4));
        else if (k == 2) alloc_run($urandom_range(1, 6), $urandom_range(0, 3));
        else begin
          len = $urandom_range(1, 8);
          alloc_run(len, len);
        end
      end else if (sel < 55) begin
        addr = (chain_heads.size() != 0 && $urandom_range(0, 3) != 0) ?
               chain_heads[$urandom_range(0, chain_heads.size() - 1)] :
               $urandom_range(0, 63);
        send_word(lcsa_pkg::OP_FREE, addr, 16'($urandom), $urandom,
                  $urandom_range(0, 127), $urandom_range(0, 1));
      end else if (sel < 97) begin
        found = 1'b0;
        for (int t = 0; t < 8 && !found; t++) begin
          addr = (chain_heads.size() != 0 && t < 6) ?
                 chain_heads[$urandom_range(0, chain_heads.size() - 1)] :
                 $urandom_range(0, 63);
          found = walk_is_tagged(addr);
        end
        if (found)
          send_word((sel < 75) ? lcsa_pkg::OP_WRITE : lcsa_pkg::OP_READ, addr,
                    ($urandom_range(0, 4) != 0) ? tag_on_chain(addr) : 16'($urandom),
                    $urandom, $urandom_range(0, 127), $urandom_range(0, 1));
        else begin
          len = $urandom_range(1, 4);
          alloc_run(len, len);
        end
      end else begin
        send_word(lcsa_pkg::OP_ALLOC, $urandom_range(0, 63), 16'($urandom), $urandom,
                  $urandom_range(0, 127), 1'b0);
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  // Receiver stalls: the pop pattern changes mode every so often.
  int pop_cycle;
  int pop_mode;
  always @(negedge clk) begin
    pop_cycle++;
    if (pop_cycle % 97 == 0) pop_mode = $urandom_range(0, 2);
    pop <= (pop_mode == 0) ? 1'b1 :
           (pop_mode == 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    lcsa_pkg::res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_head_addr !== want.head_addr || out_read_value !== want.read_value ||
            out_status !== want.status || out_run_done !== want.run_done ||
            out_free_count !== want.free_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Word %0d mismatch: head %0d/%0d value %h/%h status %0d/%0d ",
                      "done %0d/%0d free %0d/%0d (exp/got)"},
                     words_checked, want.head_addr, out_head_addr, want.read_value,
                     out_read_value, want.status, out_status, want.run_done,
                     out_run_done, want.free_count, out_free_count);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    in_op         = lcsa_pkg::OP_ALLOC;
    in_chain_addr = '0;
    in_tag        = '0;
    in_value      = '0;
    in_run_count  = '0;
    in_run_first  = 1'b0;
    send_burst    = 0;
    words_sent    = 0;
    words_checked = 0;
    mismatches    = 0;
    reset_pool();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_alloc_and_access();
    test_run_conflicts();
    test_random_traffic(830);

    drain_results();
    repeat (400) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d words, checked %0d results: %0d completed runs, %0d refusals.",
             words_sent, words_checked, ok_runs, refusals);
    $display("Read hits %0d, final free cells %0d, mismatches %0d.",
             read_hits, free_cells, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
